### hw/rtl/oai_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oai_pkg: shared types and constants for the ordered array core
// Request and status codes, the command broadcast along the cell chain,
// and the fixed field widths of the request and result beats.
// ----------------------------------------------------------------------------
package oai_pkg;

    // field widths of the request and result beats
    localparam int REQ_W   = 2;
    localparam int POS_W   = 5;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int LEN_W   = 5;

    // width used for comparing indexes and counts (holds up to 511)
    localparam int IDX_W   = 9;

    // request kinds
    typedef enum logic [REQ_W-1:0] {
        REQ_READ   = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_NONE   = 2'd3
    } req_code_t;

    // result status
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // what every cell does on the next edge
    typedef enum logic [1:0] {
        MODE_HOLD   = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_REMOVE = 2'd2
    } cell_mode_t;

    // command broadcast to all cells
    typedef struct packed {
        cell_mode_t         mode;
        logic [POS_W-1:0]   position;
        logic [DATA_W-1:0]  value;
    } cell_cmd_t;

endpackage : oai_pkg

### hw/rtl/ordered_array_insert_remove_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_array_insert_remove_core: positional list with insert and remove
// A chain of DEPTH cells holds the list; inserts shift the later words up,
// removes shift them down, all cells moving in the same cycle. Each request
// beat gives one result beat with status, new length and the word read.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  request | in        | in_valid / in_ready | req_type, position, new_value
//  result  | out       | out_valid/out_ready | status, length, read_value
//
//  one request per cycle while no stalled result fills the output register;
//  its result appears in the output register in the cycle after the request beat.
//  all cells shift in parallel on the request beat, so insert and remove cost
//  the same as a read.
//  reset clears the count and the output valid; slot words are not reset.
//  a stalled result blocks a new request only while the output register is
//  still full.
// ----------------------------------------------------------------------------
module ordered_array_insert_remove_core #(
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [oai_pkg::REQ_W-1:0]  req_type,
    input  logic [oai_pkg::POS_W-1:0]  position,
    input  logic signed [oai_pkg::DATA_W-1:0] new_value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [oai_pkg::STAT_W-1:0] status,
    output logic [oai_pkg::LEN_W-1:0]  length,
    output logic signed [oai_pkg::DATA_W-1:0] read_value
);
    import oai_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(DEPTH);

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    status_t           status_reg;
    status_t           status_next;
    logic [LEN_W-1:0]  length_reg;
    logic [DATA_W-1:0] read_value_reg;
    logic [DATA_W-1:0] read_value_next;

    logic              in_fire;
    req_code_t         req;
    logic [IDX_W-1:0]  pos_ext;
    logic [IDX_W-1:0]  cnt_ext;
    logic              in_range;
    logic              ins_full;
    cell_cmd_t         cmd;
    logic [DATA_W-1:0] tapped;

    logic [DATA_W-1:0] cell_data [DEPTH];
    logic [DATA_W-1:0] cell_tap  [DEPTH];

    // handshake
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // request decode and range checks
    assign req      = req_code_t'(req_type);
    assign pos_ext  = IDX_W'(position);
    assign cnt_ext  = IDX_W'(count_reg);
    assign in_range = (pos_ext < cnt_ext);
    assign ins_full = (cnt_ext == DEPTH_IDX);

    // word at the requested index, or-ed over the cell taps
    always_comb
    begin
        tapped = '0;
        for (int i = 0; i < DEPTH; i++)
            tapped = tapped | cell_tap[i];
    end

    // chain command, result fields and next count
    always_comb
    begin
        cmd.mode        = MODE_HOLD;
        cmd.position    = position;
        cmd.value       = new_value;
        status_next     = ST_OK;
        read_value_next = '0;
        count_next      = count_reg;
        unique case (req)
            REQ_READ:
            begin
                if (in_range)
                    read_value_next = tapped;
                else
                    status_next = ST_RANGE;
            end
            REQ_INSERT:
            begin
                if (pos_ext > cnt_ext)
                    status_next = ST_RANGE;
                else if (ins_full)
                    status_next = ST_FULL;
                else
                begin
                    cmd.mode   = in_fire ? MODE_INSERT : MODE_HOLD;
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_REMOVE:
            begin
                if (in_range)
                begin
                    read_value_next = tapped;
                    cmd.mode        = in_fire ? MODE_REMOVE : MODE_HOLD;
                    count_next      = count_reg - 1'b1;
                end
                else
                    status_next = ST_RANGE;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
                count_reg <= count_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            status_reg     <= status_next;
            length_reg     <= LEN_W'(count_next);
            read_value_reg <= read_value_next;
        end
    end

    // cell chain
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [DATA_W-1:0] lower;
        logic [DATA_W-1:0] upper;

        if (g == 0)
        begin : g_bottom
            assign lower = '0;
        end
        else
        begin : g_lower
            assign lower = cell_data[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_top
            assign upper = cell_data[g];
        end
        else
        begin : g_upper
            assign upper = cell_data[g+1];
        end

        oai_cell #(
            .INDEX (g)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .lower_data (lower),
            .upper_data (upper),
            .data       (cell_data[g]),
            .tap        (cell_tap[g])
        );
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign length     = length_reg;
    assign read_value = read_value_reg;

    // count never goes past the chain depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        IDX_W'(count_reg) <= DEPTH_IDX)
        else $error("count above depth");

    // a rejected request leaves the count alone
    a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (status_next != ST_OK) |=> count_reg == $past(count_reg))
        else $error("rejected request changed count");

    // reported length matches the count after the request
    a_length_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> length_reg == LEN_W'(count_reg))
        else $error("length differs from count");

    // failed results carry no word
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != ST_OK) |-> read_value_reg == '0)
        else $error("failed result carries a word");

endmodule : ordered_array_insert_remove_core

### hw/rtl/oai_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oai_cell: one slot of the ordered array chain
// Holds one word. On an insert it loads the new word at the target index or
// takes its lower neighbor above it; on a remove it takes its upper neighbor
// from the target index on. Drives its word onto a tap when it is addressed.
// ----------------------------------------------------------------------------
module oai_cell #(
    parameter int INDEX = 0
) (
    input  logic                       clk,
    input  oai_pkg::cell_cmd_t         cmd,
    input  logic [oai_pkg::DATA_W-1:0] lower_data,
    input  logic [oai_pkg::DATA_W-1:0] upper_data,
    output logic [oai_pkg::DATA_W-1:0] data,
    output logic [oai_pkg::DATA_W-1:0] tap
);
    import oai_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic [IDX_W-1:0]  pos_ext;
    logic              at_pos;
    logic              above_pos;

    // position compare against this cell's index
    assign pos_ext   = IDX_W'(cmd.position);
    assign at_pos    = (MY_IDX == pos_ext);
    assign above_pos = (MY_IDX > pos_ext);

    // next word for this slot
    always_comb
    begin
        data_next = data_reg;
        case (cmd.mode)
            MODE_INSERT:
            begin
                if (at_pos)
                    data_next = cmd.value;
                else if (above_pos)
                    data_next = lower_data;
            end
            MODE_REMOVE:
            begin
                if (at_pos || above_pos)
                    data_next = upper_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // slot storage, payload only
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    // addressed word, zero elsewhere so the taps can be or-ed together
    assign tap  = at_pos ? data_reg : '0;

endmodule : oai_cell

### dv/ordered_array_insert_remove_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_array_insert_remove_core_test: self-checking bench for the list core
// Streams read, insert, remove and no-op requests through the request channel
// with random gaps and result stalls. Each request beat updates a local copy
// of the list and queues the result it should give. Result beats are compared
// field by field, in order, against that queue.
// ----------------------------------------------------------------------------
module ordered_array_insert_remove_core_test;

    import oai_pkg::*;

    localparam int LIST_DEPTH   = 16;
    localparam int RANDOM_ITEMS = 925;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;

    // one request beat
    typedef struct packed {
        req_code_t                kind;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
    } list_request_t;

    // one result beat
    typedef struct packed {
        status_t                  status;
        logic [LEN_W-1:0]         len;
        logic signed [DATA_W-1:0] rd;
    } list_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [REQ_W-1:0]           req_type = '0;
    logic [POS_W-1:0]           position = '0;
    logic signed [DATA_W-1:0]   new_value = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [STAT_W-1:0]          status;
    logic [LEN_W-1:0]           length;
    logic signed [DATA_W-1:0]   read_value;

    // stimulus and expectations
    list_request_t              pending_reqs[$];
    list_result_t               expected_results[$];
    list_request_t              next_req;
    list_result_t               due_result;

    // local copy of the list
    logic signed [DATA_W-1:0]   list_words[LIST_DEPTH];
    int                         list_len = 0;
    int                         gen_len = 0;

    // bookkeeping
    int                         cycle_count = 0;
    int                         requests_sent = 0;
    int                         results_seen = 0;
    int                         error_count = 0;
    int                         kind_count[4] = '{0, 0, 0, 0};
    int                         range_hits = 0;
    int                         full_hits = 0;
    int                         peak_len = 0;

    ordered_array_insert_remove_core #(
        .DEPTH      (LIST_DEPTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .position   (position),
        .new_value  (new_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .length     (length),
        .read_value (read_value)
    );

    // clock
    always #5 clk = ~clk;

    // apply one request to the local list and return the result it gives
    function automatic list_result_t apply_request(list_request_t r);
        list_result_t res;
        int           idx;
        res.status = ST_OK;
        res.rd     = '0;
        case (r.kind)
            REQ_READ:
            begin
                if (r.pos < list_len)
                    res.rd = list_words[r.pos];
                else
                    res.status = ST_RANGE;
            end
            REQ_INSERT:
            begin
                // range check wins over the full check
                if (r.pos > list_len)
                begin
                    res.status = ST_RANGE;
                end
                else if (list_len >= LIST_DEPTH)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    for (idx = list_len; idx > r.pos; idx--)
                        list_words[idx] = list_words[idx-1];
                    list_words[r.pos] = r.value;
                    list_len++;
                end
            end
            REQ_REMOVE:
            begin
                if (r.pos < list_len)
                begin
                    res.rd = list_words[r.pos];
                    for (idx = r.pos; idx + 1 < list_len; idx++)
                        list_words[idx] = list_words[idx+1];
                    list_len--;
                end
                else
                begin
                    res.status = ST_RANGE;
                end
            end
            REQ_NONE: ;
            default: ;
        endcase
        res.len = list_len[LEN_W-1:0];
        return res;
    endfunction

    // queue a request and track the count it leaves behind
    task automatic add_req(req_code_t kind, int pos, logic signed [DATA_W-1:0] value);
        list_request_t r;
        r.kind  = kind;
        r.pos   = pos[POS_W-1:0];
        r.value = value;
        pending_reqs.push_back(r);
        kind_count[kind]++;
        if (kind == REQ_INSERT && r.pos <= gen_len && gen_len < LIST_DEPTH)
            gen_len++;
        else if (kind == REQ_REMOVE && r.pos < gen_len)
            gen_len--;
    endtask

    // data word, with the extremes showing up now and then
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -32'sd1;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    // index up to top_idx, occasionally anywhere the field allows
    function automatic int pick_pos(int top_idx);
        if (top_idx < 0 || $urandom_range(0, 99) < 10)
            return $urandom_range(0, (1 << POS_W) - 1);
        return $urandom_range(0, top_idx);
    endfunction

    // random part: bursts that fill, drain, mix or throw noise
    task automatic build_random_reqs();
        int        burst_mode;
        int        burst_len;
        int        b;
        int        goal;
        req_code_t kind;
        goal = pending_reqs.size() + RANDOM_ITEMS;
        while (pending_reqs.size() < goal)
        begin
            burst_mode = $urandom_range(0, 9);
            burst_len  = $urandom_range(4, 30);
            for (b = 0; b < burst_len && pending_reqs.size() < goal; b++)
            begin
                if (burst_mode <= 2)
                begin
                    // fill, running into the full list now and then
                    if ($urandom_range(0, 99) < 85)
                        add_req(REQ_INSERT, pick_pos(gen_len), pick_value());
                    else
                        add_req(REQ_READ, pick_pos(gen_len - 1), pick_value());
                end
                else if (burst_mode <= 4)
                begin
                    // drain
                    if ($urandom_range(0, 99) < 85)
                        add_req(REQ_REMOVE, pick_pos(gen_len - 1), pick_value());
                    else
                        add_req(REQ_READ, pick_pos(gen_len - 1), pick_value());
                end
                else if (burst_mode <= 8)
                begin
                    // mixed traffic, mostly on valid indexes
                    if ($urandom_range(0, 99) < 5)
                        kind = REQ_NONE;
                    else
                        kind = req_code_t'($urandom_range(0, 2));
                    if (kind == REQ_INSERT)
                        add_req(kind, pick_pos(gen_len), pick_value());
                    else
                        add_req(kind, pick_pos(gen_len - 1), pick_value());
                end
                else
                begin
                    // noise over the whole field range
                    add_req(req_code_t'($urandom_range(0, 3)),
                            $urandom_range(0, (1 << POS_W) - 1), pick_value());
                end
            end
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            req_type  <= '0;
            position  <= '0;
            new_value <= '0;
        end
        else
        begin
            // accepted beat: predict its result
            if (in_valid && in_ready)
            begin
                next_req.kind  = req_code_t'(req_type);
                next_req.pos   = position;
                next_req.value = new_value;
                expected_results.push_back(apply_request(next_req));
                if (list_len > peak_len)
                    peak_len = list_len;
                requests_sent++;
            end
            // load the next beat, with gaps outside the no-gap stretch
            if (!in_valid || in_ready)
            begin
                if (pending_reqs.size() != 0 &&
                    !(!(requests_sent >= 400 && requests_sent < 650) &&
                      $urandom_range(0, 99) < 10))
                begin
                    next_req   = pending_reqs.pop_front();
                    in_valid  <= 1'b1;
                    req_type  <= next_req.kind;
                    position  <= next_req.pos;
                    new_value <= next_req.value;
                end
                else
                begin
                    in_valid  <= 1'b0;
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("[%0t] unexpected result beat: %0d/%0d/%0d",
                                 $realtime, status, length, read_value);
                end
                else
                begin
                    due_result = expected_results.pop_front();
                    if (due_result.status == ST_RANGE)
                        range_hits++;
                    if (due_result.status == ST_FULL)
                        full_hits++;
                    if (status !== due_result.status || length !== due_result.len ||
                        read_value !== due_result.rd)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("[%0t] result %0d mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     $realtime, results_seen, due_result.status,
                                     due_result.len, due_result.rd, status, length,
                                     read_value);
                    end
                end
            end
            // stall outside the no-stall stretch
            out_ready <= !(!(results_seen >= 150 && results_seen < 400) &&
                           $urandom_range(0, 99) < 10);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        // empty list: every access is out of range, no-op leaves it alone
        add_req(REQ_READ,   0, '0);
        add_req(REQ_REMOVE, 0, '0);
        add_req(REQ_INSERT, 1, 32'sh1234_5678);
        add_req(REQ_NONE,  31, -32'sd1);
        // head, head, tail and middle inserts with extreme words
        add_req(REQ_INSERT, 0, 32'sh8000_0000);
        add_req(REQ_INSERT, 0, 32'sh7fff_ffff);
        add_req(REQ_INSERT, 2, '0);
        add_req(REQ_INSERT, 1, 32'sh5555_5555);
        // fill to the top
        while (gen_len < LIST_DEPTH)
            add_req(REQ_INSERT, $urandom_range(0, gen_len), $urandom);
        // full list: past-the-end beats full, then plain full
        add_req(REQ_INSERT, LIST_DEPTH + 1, 32'shaaaa_aaaa);
        add_req(REQ_INSERT, 0, 32'shaaaa_aaaa);
        add_req(REQ_READ,   LIST_DEPTH - 1, '0);
        add_req(REQ_READ,   LIST_DEPTH, '0);
        add_req(REQ_READ,   31, '0);
        add_req(REQ_REMOVE, LIST_DEPTH - 1, '0);
        add_req(REQ_REMOVE, 0, '0);
        build_random_reqs();

        // reset
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // wait for every request to go in and every result to come out
        while (pending_reqs.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d requests: %0d reads, %0d inserts, %0d removes, %0d no-ops",
                 requests_sent, kind_count[REQ_READ], kind_count[REQ_INSERT],
                 kind_count[REQ_REMOVE], kind_count[REQ_NONE]);
        $display("%0d results checked, %0d out of range, %0d list full, peak length %0d",
                 results_seen, range_hits, full_hits, peak_len);
        $display("%0d errors", error_count);
        if (error_count == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/oai_pkg.sv
hw/rtl/oai_cell.sv
hw/rtl/ordered_array_insert_remove_core.sv
dv/ordered_array_insert_remove_core_test.sv
